// ===== rtl/core/multicast_hash_filter_builder_macros.svh =====
// Assertion helpers for the multicast hash filter builder
`ifndef MULTICAST_HASH_FILTER_BUILDER_MACROS_SVH
`define MULTICAST_HASH_FILTER_BUILDER_MACROS_SVH

// Implication checked on every rising clock edge, off during reset
`define MHF_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked on every rising clock edge, off during reset
`define MHF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/mhf_pkg.sv =====
`default_nettype none
package mhf_pkg;

   localparam int unsigned ADDRESS_BYTES = 6;
   localparam int unsigned MAC_WIDTH     = 48;
   localparam int unsigned INDEX_WIDTH   = 6;
   localparam int unsigned TABLE_WIDTH   = 64;
   localparam int unsigned HALF_WIDTH    = 32;
   localparam int unsigned CRC_WIDTH     = 32;
   localparam int unsigned INDEX_SHIFT   = 23;
   localparam int unsigned ADDR_BITS     = 8 * ADDRESS_BYTES;

   localparam logic [CRC_WIDTH-1:0]   CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [CRC_WIDTH-1:0]   CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [INDEX_WIDTH-1:0] INDEX_MASK = 6'h3F;

   typedef logic [MAC_WIDTH-1:0]   mac_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [TABLE_WIDTH-1:0] table_type;

   // one entry moving from the input register to the result register
   typedef struct packed {
      logic      fire;
      logic      valid;
      logic      last;
      index_type index;
   } update_type;

   // address bytes first byte first, each byte lsb first; bits above 47 read as zero
   function automatic logic [CRC_WIDTH-1:0] addr_crc(input mac_type addr);
      logic [CRC_WIDTH-1:0] crc;
      logic [63:0]          ext;
      logic                 fb;
      int unsigned          k;
      int unsigned          b;
      crc = CRC_PRESET;
      ext = {{(64-MAC_WIDTH){1'b0}}, addr};
      for (int unsigned n = 0; n < ADDR_BITS; n++) begin
         k   = n / 8;
         b   = n % 8;
         fb  = crc[CRC_WIDTH-1] ^ ext[8*(ADDRESS_BYTES-1-k) + b];
         crc = {crc[CRC_WIDTH-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/multicast_hash_filter_builder.sv =====
// Multicast hash filter builder. One filter entry per beat on req_ builds a 64-bit
// multicast hash table: a valid entry sets the bit chosen by CRC-32 bits 28 to 23 of
// its address, and every entry gives one rsp_ beat with the index and the table after
// it. The entry flagged last_entry returns the finished table with table_complete set
// and the table then clears. An entry is registered on acceptance, hashed by an
// unrolled CRC network and table update, moved into the result register once that
// register is free or being taken, and held there until taken; one entry per cycle
// sustained while rsp_ready stays high.
`default_nettype none
`include "multicast_hash_filter_builder_macros.svh"
module multicast_hash_filter_builder
   import mhf_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire [MAC_WIDTH-1:0]   req_mac_address,
   input  wire                   req_entry_valid,
   input  wire                   req_last_entry,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [INDEX_WIDTH-1:0] rsp_hash_index,
   output logic                  rsp_index_used,
   output logic [HALF_WIDTH-1:0] rsp_table_low,
   output logic [HALF_WIDTH-1:0] rsp_table_high,
   output logic                  rsp_table_complete
);

   logic      in_valid_ff;
   logic      in_valid_in;
   mac_type   in_mac_ff;
   logic      in_entry_ff;
   logic      in_last_ff;

   logic      out_valid_ff;
   logic      out_valid_in;
   index_type out_index_ff;
   logic      out_used_ff;
   table_type out_table_ff;
   logic      out_last_ff;

   logic       advance;
   logic       accept;
   index_type  crc_index;
   update_type upd;
   table_type  table_after;
   logic       used_beat;
   logic       unused_beat;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   mhf_crc_index u_crc (
      .mac_address (in_mac_ff),
      .hash_index  (crc_index)
   );

   always_comb begin
      upd.fire  = advance;
      upd.valid = in_entry_ff;
      upd.last  = in_last_ff;
      upd.index = crc_index;
   end

   mhf_table u_table (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .table_after (table_after)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mac_ff   <= req_mac_address;
         in_entry_ff <= req_entry_valid;
         in_last_ff  <= req_last_entry;
      end
      if (advance) begin
         out_index_ff <= in_entry_ff ? crc_index : '0;
         out_used_ff  <= in_entry_ff;
         out_table_ff <= table_after;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_hash_index     = out_index_ff;
   assign rsp_index_used     = out_used_ff;
   assign rsp_table_low      = out_table_ff[HALF_WIDTH-1:0];
   assign rsp_table_high     = out_table_ff[TABLE_WIDTH-1:HALF_WIDTH];
   assign rsp_table_complete = out_last_ff;

   assign used_beat   = out_valid_ff && out_used_ff;
   assign unused_beat = out_valid_ff && !out_used_ff;

   // unused entries report index zero
   `MHF_ASSERT_IMPL(a_unused_zero, unused_beat, out_index_ff == '0, "index on unused entry")
   // a used index is set in the table it reports
   `MHF_ASSERT_IMPL(a_index_in_table, used_beat, out_table_ff[out_index_ff], "hash bit missing")
   // every entry leaving the input register lands in the result register
   `MHF_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff, "result beat lost")

endmodule
`default_nettype wire

// ===== rtl/core/mhf_crc_index.sv =====
`default_nettype none
module mhf_crc_index
   import mhf_pkg::*;
(
   input  wire mac_type   mac_address,
   output index_type      hash_index
);

   logic [CRC_WIDTH-1:0] crc;

   assign crc        = addr_crc(mac_address);
   assign hash_index = crc[INDEX_SHIFT +: INDEX_WIDTH] & INDEX_MASK;

endmodule
`default_nettype wire

// ===== rtl/core/mhf_table.sv =====
`default_nettype none
module mhf_table
   import mhf_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire update_type upd,
   output table_type       table_after
);

   table_type table_ff;
   table_type table_in;
   table_type bit_set;

   always_comb begin
      bit_set           = '0;
      bit_set[upd.index] = upd.valid;
      table_after       = table_ff | bit_set;
      table_in          = table_ff;
      if (upd.fire) begin
         table_in = upd.last ? '0 : table_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= '0;
      end else begin
         table_ff <= table_in;
      end
   end

endmodule
`default_nettype wire

// ===== sim/multicast_hash_filter_builder_test.sv =====
`timescale 1ns / 1ps
module multicast_hash_filter_builder_test;
   import mhf_pkg::*;

   localparam int DIRECTED_ROWS  = 22;
   localparam int RANDOM_ENTRIES = 1900;
   localparam int STALL_LIMIT    = 2000;

   typedef struct packed {
      index_type             hash_index;
      logic                  used;
      logic [HALF_WIDTH-1:0] low;
      logic [HALF_WIDTH-1:0] high;
      logic                  complete;
   } report_type;

   typedef struct packed {
      mac_type    mac;
      logic       entry_valid;
      logic       last_entry;
      logic       typed;
      report_type want;
   } row_type;

   localparam report_type EMPTY_REPORT = '0;
   localparam report_type EMPTY_LAST   = '{hash_index: '0, used: 1'b0, low: '0, high: '0,
                                           complete: 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [MAC_WIDTH-1:0]   req_mac_address = '0;
   logic                   req_entry_valid = 1'b0;
   logic                   req_last_entry = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [INDEX_WIDTH-1:0] rsp_hash_index;
   logic                   rsp_index_used;
   logic [HALF_WIDTH-1:0]  rsp_table_low;
   logic [HALF_WIDTH-1:0]  rsp_table_high;
   logic                   rsp_table_complete;

   table_type  filter_state = '0;
   report_type pending_reports[$];
   int         accepted_entries = 0;
   int         mismatch_count = 0;
   int         stray_reports = 0;
   int         idle_cycles = 0;
   int         gap_pct = 0;
   int         stall_pct = 0;

   row_type directed_rows [DIRECTED_ROWS] = '{
      '{48'h0000_0000_0000, 1'b0, 1'b0, 1'b1, EMPTY_REPORT},
      '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, EMPTY_LAST},
      '{48'h0000_0000_0000, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0100_5E00_0001, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h3333_0000_0001, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0180_C200_0000, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h8000_0000_0000, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0000_0000_0001, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0100_0000_0000, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0000_0000_0080, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0100_5E00_0001, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h5555_5555_5555, 1'b1, 1'b1, 1'b0, EMPTY_REPORT},
      '{48'h1234_5678_9ABC, 1'b0, 1'b0, 1'b1, EMPTY_REPORT},
      '{48'h0000_0000_0000, 1'b0, 1'b1, 1'b1, EMPTY_LAST},
      '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, EMPTY_REPORT},
      '{48'h5E00_0100_0001, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'h0100_5E7F_FFFF, 1'b1, 1'b0, 1'b0, EMPTY_REPORT},
      '{48'hFEDC_BA98_7654, 1'b0, 1'b1, 1'b0, EMPTY_REPORT},
      '{48'h0000_0000_0000, 1'b0, 1'b0, 1'b1, EMPTY_REPORT},
      '{48'h0000_0000_0000, 1'b1, 1'b1, 1'b0, EMPTY_REPORT}
   };

   multicast_hash_filter_builder DUT (.*);

   always #5 clock = ~clock;

   // first octet first, each octet lsb first
   function automatic logic [CRC_WIDTH-1:0] crc_of_address(input mac_type mac);
      logic [CRC_WIDTH-1:0] crc;
      logic [63:0]          padded;
      logic [7:0]           octet;
      logic                 feedback;
      crc    = CRC_PRESET;
      padded = {{(64-MAC_WIDTH){1'b0}}, mac};
      for (int k = 0; k < ADDRESS_BYTES; k++) begin
         octet = padded[8*(ADDRESS_BYTES-1-k) +: 8];
         for (int b = 0; b < 8; b++) begin
            feedback = crc[CRC_WIDTH-1] ^ octet[b];
            crc      = {crc[CRC_WIDTH-2:0], 1'b0} ^ (feedback ? CRC_POLY : '0);
         end
      end
      return crc;
   endfunction

   function automatic report_type apply_entry(input mac_type mac, input logic entry_valid,
                                              input logic last_entry);
      report_type           r;
      logic [CRC_WIDTH-1:0] crc;
      r = '0;
      if (entry_valid) begin
         crc          = crc_of_address(mac);
         r.hash_index = crc[INDEX_SHIFT +: INDEX_WIDTH];
         filter_state[r.hash_index] = 1'b1;
      end
      r.used     = entry_valid;
      r.low      = filter_state[HALF_WIDTH-1:0];
      r.high     = filter_state[TABLE_WIDTH-1:HALF_WIDTH];
      r.complete = last_entry;
      if (last_entry) begin
         filter_state = '0;
      end
      return r;
   endfunction

   task automatic send_entry(input mac_type mac, input logic entry_valid, input logic last_entry);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mac_address <= mac;
      req_entry_valid <= entry_valid;
      req_last_entry  <= last_entry;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // result beats checked before the request beat of the same edge is predicted
   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hash_index, rsp_index_used, rsp_table_low, rsp_table_high,
                    rsp_table_complete};
            if (pending_reports.size() == 0) begin
               stray_reports++;
               if (mismatch_count + stray_reports <= 10) begin
                  $display("unexpected beat: index %0d used %0b low %h high %h complete %0b",
                           got.hash_index, got.used, got.low, got.high, got.complete);
               end
            end else begin
               want = pending_reports.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count + stray_reports <= 10) begin
                     $display("mismatch (exp/act): index %0d/%0d used %0b/%0b low %h/%h",
                              want.hash_index, got.hash_index, want.used, got.used,
                              want.low, got.low);
                     $display("   high %h/%h complete %0b/%0b",
                              want.high, got.high, want.complete, got.complete);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_entry(req_mac_address, req_entry_valid, req_last_entry);
            if (accepted_entries < DIRECTED_ROWS && directed_rows[accepted_entries].typed) begin
               want = directed_rows[accepted_entries].want;
            end
            pending_reports.push_back(want);
            accepted_entries++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mac_type     mac;
      logic [63:0] wide;
      int          sent;
      int          run_length;
      logic        last_entry;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_entry(directed_rows[i].mac, directed_rows[i].entry_valid,
                    directed_rows[i].last_entry);
      end

      sent = 0;
      while (sent < RANDOM_ENTRIES) begin
         case (sent * 4 / RANDOM_ENTRIES)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 50;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 50;
            end
            default: begin
               gap_pct   = 14;
               stall_pct = 14;
            end
         endcase
         // mostly short rebuilds, now and then long enough to fill the table
         run_length = ($urandom_range(9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 24);
         for (int n = 0; n < run_length && sent < RANDOM_ENTRIES; n++) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(9))
               0, 1: begin
                  mac     = wide[MAC_WIDTH-1:0];
                  mac[40] = 1'b1;
               end
               2: mac = $urandom_range(1) ? '0 : '1;
               3: mac = mac_type'(1) << $urandom_range(MAC_WIDTH - 1);
               4: mac = {24'h01005E, 1'b0, wide[22:0]};
               default: mac = wide[MAC_WIDTH-1:0];
            endcase
            last_entry = (n == run_length - 1) || ($urandom_range(99) < 3);
            send_entry(mac, $urandom_range(99) < 85, last_entry);
            sent++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && stray_reports == 0 && pending_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mhf_pkg.sv
rtl/core/mhf_crc_index.sv
rtl/core/mhf_table.sv
rtl/core/multicast_hash_filter_builder.sv
sim/multicast_hash_filter_builder_test.sv
